>>> rtl/pse_pkg.sv
// pse_pkg: shared types and constants of the postfix stack evaluator
// word widths, operator characters, status codes, controller states and the
// command and status bundles between controller and datapath
package pse_pkg;

  localparam int DATA_W  = 32;
  localparam int DEPTH_W = 7;

  localparam logic [7:0] CHAR_ADD = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SUB = 8'h2D;  // '-'
  localparam logic [7:0] CHAR_MUL = 8'h2A;  // '*'
  localparam logic [7:0] CHAR_DIV = 8'h2F;  // '/'

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FEW     = 3'd1,
    ST_DIV0    = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_FULL    = 3'd4,
    ST_SAT     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV,
    ALU_BAD
  } alu_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_MUL,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic    load_in;
    logic    push;
    logic    rd_issue;
    logic    mul_en;
    logic    div_start;
    logic    commit;
    logic    set_status;
    status_t status;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic    is_op;
    logic    few;
    logic    full;
    alu_op_t kind;
    logic    b_zero;
    logic    div_done;
    logic    out_free;
  } dp_stat_t;

  function automatic alu_op_t decode_op(input logic [7:0] code);
    alu_op_t k;
    case (code)
      CHAR_ADD: k = ALU_ADD;
      CHAR_SUB: k = ALU_SUB;
      CHAR_MUL: k = ALU_MUL;
      CHAR_DIV: k = ALU_DIV;
      default:  k = ALU_BAD;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/postfix_stack_evaluator_unit.sv
// channel  dir  tdata (low bit up)                          tuser
// s_*      in   number[31:0] operator_code[39:32]           cmd[0]
// m_*      out  status[2:0] top_value[34:3] depth[41:35]     -
//               single_result[42] zero[47:43]
//
// one token at a time: push passes IDLE, DECODE and OUT; add/sub also READ,
// multiply READ, MUL; divide READ, DIV (one quotient bit a cycle in the divider)
// rst clears the stack count, the state machine and the output word valid
// a new token is taken while the previous word waits on m_tready
// postfix_stack_evaluator_unit: top level, uses pse_pkg, pse_ctrl, pse_dp
module postfix_stack_evaluator_unit #(
  parameter int STACK_DEPTH = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // number[31:0], operator_code[39:32]
  input  logic [0:0]  s_tuser,   // cmd[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // status, top_value, depth, single_result, zero
);

  pse_pkg::dp_cmd_t  cmd;
  pse_pkg::dp_stat_t stat;

  logic [2:0]                        out_status;
  logic signed [pse_pkg::DATA_W-1:0] out_top;
  logic [pse_pkg::DEPTH_W-1:0]       out_depth;
  logic                              out_single;

  pse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pse_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_cmd     (s_tuser[0]),
    .in_number  (s_tdata[31:0]),
    .in_op      (s_tdata[39:32]),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .out_status (out_status),
    .out_top    (out_top),
    .out_depth  (out_depth),
    .out_single (out_single)
  );

  assign m_tdata = {5'b0, out_single, out_depth, out_top, out_status};

endmodule

>>> rtl/pse_div.sv
// pse_div: restoring unsigned divider, one quotient bit per cycle
// standalone; sized by the dividend width NW and divisor width DW
module pse_div #(
  parameter int NW = 48,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [DW-1:0]    rem;
  logic [DW-1:0]    dvs;
  logic [NW-1:0]    quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DW:0]      shifted;
  logic             ge;

  assign shifted  = {rem, quo[NW-1]};
  assign ge       = shifted >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NW);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      // remainder stays below the divisor, so the low bits suffice
      if (ge) begin
        rem <= DW'(shifted - {1'b0, dvs});
      end else begin
        rem <= shifted[DW-1:0];
      end
      quo <= {quo[NW-2:0], ge};
    end
  end

endmodule

>>> rtl/pse_ctrl.sv
// pse_ctrl: sequencing state machine of the postfix stack evaluator
// uses pse_pkg for states and the command and status bundles
module pse_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  pse_pkg::dp_stat_t stat,
  output pse_pkg::dp_cmd_t  cmd
);

  pse_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pse_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.status = pse_pkg::ST_OK;
    s_tready   = 1'b0;
    case (state)
      pse_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = pse_pkg::S_DECODE;
        end
      end
      pse_pkg::S_DECODE: begin
        state_next     = pse_pkg::S_OUT;
        cmd.set_status = 1'b1;
        if (!stat.is_op) begin
          if (stat.full) begin
            cmd.status = pse_pkg::ST_FULL;
          end else begin
            cmd.push = 1'b1;
          end
        end else if (stat.few) begin
          cmd.status = pse_pkg::ST_FEW;
        end else if (stat.kind == pse_pkg::ALU_BAD) begin
          cmd.status = pse_pkg::ST_UNKNOWN;
        end else if (stat.kind == pse_pkg::ALU_DIV && stat.b_zero) begin
          cmd.status = pse_pkg::ST_DIV0;
        end else begin
          // operand a, below the top, comes out of the stack memory next cycle
          cmd.set_status = 1'b0;
          cmd.rd_issue   = 1'b1;
          state_next     = pse_pkg::S_READ;
        end
      end
      pse_pkg::S_READ: begin
        case (stat.kind)
          pse_pkg::ALU_ADD, pse_pkg::ALU_SUB: begin
            cmd.commit = 1'b1;
            state_next = pse_pkg::S_OUT;
          end
          pse_pkg::ALU_MUL: begin
            cmd.mul_en = 1'b1;
            state_next = pse_pkg::S_MUL;
          end
          pse_pkg::ALU_DIV: begin
            cmd.div_start = 1'b1;
            state_next    = pse_pkg::S_DIV;
          end
          default: begin
            state_next = pse_pkg::S_OUT;
          end
        endcase
      end
      pse_pkg::S_MUL: begin
        cmd.commit = 1'b1;
        state_next = pse_pkg::S_OUT;
      end
      pse_pkg::S_DIV: begin
        if (stat.div_done) begin
          cmd.commit = 1'b1;
          state_next = pse_pkg::S_OUT;
        end
      end
      pse_pkg::S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = pse_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pse_pkg::S_IDLE;
      end
    endcase
  end

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> state == pse_pkg::S_DIV)
    else $error("divider finished outside its wait state");

endmodule

>>> rtl/pse_dp.sv
// pse_dp: datapath of the postfix stack evaluator: stack memory, top register,
// adder, multiplier, divider and the output word register
// uses pse_pkg and pse_div
module pse_dp #(
  parameter int STACK_DEPTH = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  pse_pkg::dp_cmd_t               cmd,
  output pse_pkg::dp_stat_t              stat,
  input  logic                           in_cmd,
  input  logic signed [pse_pkg::DATA_W-1:0] in_number,
  input  logic [7:0]                     in_op,
  input  logic                           m_tready,
  output logic                           m_tvalid,
  output logic [2:0]                     out_status,
  output logic signed [pse_pkg::DATA_W-1:0] out_top,
  output logic [pse_pkg::DEPTH_W-1:0]    out_depth,
  output logic                           out_single
);

  localparam int DW = pse_pkg::DATA_W;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int NW = DW + FRAC_BITS;
  localparam logic signed [2*DW-1:0] MAX_W = 64'sd2147483647;
  localparam logic signed [2*DW-1:0] MIN_W = -64'sd2147483648;

  logic                 op_flag;
  logic signed [DW-1:0] num;
  pse_pkg::alu_op_t     kind;
  logic [CW-1:0]        count;
  logic [CW-1:0]        cnt_m1;
  logic [CW-1:0]        cnt_m2;
  logic signed [DW-1:0] top_reg;
  logic signed [DW-1:0] rd_data;
  logic [DW-1:0]        mem [STACK_DEPTH];
  pse_pkg::status_t     status_reg;

  logic signed [2*DW-1:0] prod_next;
  logic signed [2*DW-1:0] prod_reg;
  logic signed [2*DW-1:0] prod_sh;
  logic [DW:0]            sum;
  logic [DW:0]            diff;
  logic [DW-1:0]          mag_a;
  logic [DW-1:0]          mag_b;
  logic                   div_neg;
  logic                   div_done;
  logic [NW-1:0]          quo;
  logic signed [DW-1:0]   res;
  logic                   res_sat;
  logic [CW+pse_pkg::DEPTH_W-1:0] cnt_ext;

  assign cnt_m1 = count - CW'(1);
  assign cnt_m2 = count - CW'(2);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_flag <= in_cmd;
      num     <= in_number;
      kind    <= pse_pkg::decode_op(in_op);
    end
  end

  // stack memory holds every entry below the top one
  always_ff @(posedge clk) begin
    if (cmd.push && count != '0) begin
      mem[cnt_m1[AW-1:0]] <= top_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_data <= mem[cnt_m2[AW-1:0]];
    end
  end

  // operands: a from memory, b is the top register
  assign sum       = {rd_data[DW-1], rd_data} + {top_reg[DW-1], top_reg};
  assign diff      = {rd_data[DW-1], rd_data} - {top_reg[DW-1], top_reg};
  assign prod_next = rd_data * top_reg;
  assign prod_sh   = prod_reg >>> FRAC_BITS;
  assign mag_a     = rd_data[DW-1] ? DW'(-rd_data) : DW'(rd_data);
  assign mag_b     = top_reg[DW-1] ? DW'(-top_reg) : DW'(top_reg);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_reg <= prod_next;
    end
    if (cmd.div_start) begin
      div_neg <= rd_data[DW-1] ^ top_reg[DW-1];
    end
  end

  pse_div #(.NW(NW), .DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (NW'(mag_a) << FRAC_BITS),
    .divisor  (mag_b),
    .done     (div_done),
    .quotient (quo)
  );

  always_comb begin
    res     = '0;
    res_sat = 1'b0;
    case (kind)
      pse_pkg::ALU_ADD: begin
        res_sat = sum[DW] != sum[DW-1];
        res     = res_sat ? {sum[DW], {(DW-1){~sum[DW]}}} : sum[DW-1:0];
      end
      pse_pkg::ALU_SUB: begin
        res_sat = diff[DW] != diff[DW-1];
        res     = res_sat ? {diff[DW], {(DW-1){~diff[DW]}}} : diff[DW-1:0];
      end
      pse_pkg::ALU_MUL: begin
        if (prod_sh > MAX_W) begin
          res_sat = 1'b1;
          res     = MAX_W[DW-1:0];
        end else if (prod_sh < MIN_W) begin
          res_sat = 1'b1;
          res     = MIN_W[DW-1:0];
        end else begin
          res = prod_sh[DW-1:0];
        end
      end
      pse_pkg::ALU_DIV: begin
        if (div_neg) begin
          if (quo > NW'(32'h8000_0000)) begin
            res_sat = 1'b1;
            res     = MIN_W[DW-1:0];
          end else begin
            res = DW'(-quo[DW-1:0]);
          end
        end else begin
          if (quo > NW'(32'h7FFF_FFFF)) begin
            res_sat = 1'b1;
            res     = MAX_W[DW-1:0];
          end else begin
            res = quo[DW-1:0];
          end
        end
      end
      default: begin
        res     = '0;
        res_sat = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.push) begin
      count <= count + CW'(1);
    end else if (cmd.commit) begin
      count <= cnt_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      top_reg <= num;
    end else if (cmd.commit) begin
      top_reg <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_status) begin
      status_reg <= cmd.status;
    end else if (cmd.commit) begin
      status_reg <= res_sat ? pse_pkg::ST_SAT : pse_pkg::ST_OK;
    end
  end

  // output word register
  assign cnt_ext = {{pse_pkg::DEPTH_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= status_reg;
      out_top    <= (count != '0) ? top_reg : '0;
      out_depth  <= cnt_ext[pse_pkg::DEPTH_W-1:0];
      out_single <= count == CW'(1);
    end
  end

  assign stat.is_op    = op_flag;
  assign stat.few      = count < CW'(2);
  assign stat.full     = count == CW'(STACK_DEPTH);
  assign stat.kind     = kind;
  assign stat.b_zero   = top_reg == '0;
  assign stat.div_done = div_done;
  assign stat.out_free = !m_tvalid || m_tready;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_commit_two: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> count >= CW'(2))
    else $error("operator committed with fewer than two entries");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("output word overwritten before taken");

endmodule

>>> sim/tb_postfix_stack_evaluator_unit.sv
// tb_postfix_stack_evaluator_unit: self-checking bench for the rpn stack evaluator
// drives tokens on the s_* stream and checks every m_* word against a stack predictor
// depends on pse_pkg and postfix_stack_evaluator_unit
module tb_postfix_stack_evaluator_unit;

  localparam int     STACK_DEPTH   = 64;
  localparam int     FRAC_BITS     = 16;
  localparam int     RANDOM_TOKENS = 1500;
  localparam int     LONG_HOLD     = 300;
  localparam int     TAIL_CYCLES   = 80;
  localparam longint Q_MAX         = 64'sd2147483647;
  localparam longint Q_MIN         = -64'sd2147483648;

  typedef struct {
    pse_pkg::status_t status;
    logic [31:0]      top;
    logic [6:0]       depth;
    logic             single;
  } rpn_result_t;

  // predicts the stack after each accepted token and checks the words that come back
  class rpn_checker;
    logic signed [31:0] entries[STACK_DEPTH];
    int                 depth_now;
    rpn_result_t        pending[$];
    int                 errors;

    function new();
      depth_now = 0;
      errors    = 0;
    endfunction

    function void note_token(bit is_op, logic signed [31:0] num, logic [7:0] opc);
      longint           a;
      longint           b;
      longint           r;
      bit               apply;
      pse_pkg::status_t st;
      rpn_result_t      res;
      st = pse_pkg::ST_OK;
      r  = 0;
      if (!is_op) begin
        if (depth_now >= STACK_DEPTH) begin
          st = pse_pkg::ST_FULL;
        end else begin
          entries[depth_now] = num;
          depth_now++;
        end
      end else if (depth_now < 2) begin
        // operand check comes before decoding the character
        st = pse_pkg::ST_FEW;
      end else begin
        a     = entries[depth_now - 2];
        b     = entries[depth_now - 1];
        apply = 1'b1;
        case (opc)
          pse_pkg::CHAR_ADD: r = a + b;
          pse_pkg::CHAR_SUB: r = a - b;
          pse_pkg::CHAR_MUL: r = (a * b) >>> FRAC_BITS;  // floor
          pse_pkg::CHAR_DIV: begin
            if (b == 0) begin
              st    = pse_pkg::ST_DIV0;
              apply = 1'b0;
            end else begin
              r = (a <<< FRAC_BITS) / b;  // truncates toward zero
            end
          end
          default: begin
            st    = pse_pkg::ST_UNKNOWN;
            apply = 1'b0;
          end
        endcase
        if (apply) begin
          if (r > Q_MAX) begin
            r  = Q_MAX;
            st = pse_pkg::ST_SAT;
          end else if (r < Q_MIN) begin
            r  = Q_MIN;
            st = pse_pkg::ST_SAT;
          end
          depth_now--;
          entries[depth_now - 1] = r[31:0];
        end
      end
      res.status = st;
      res.top    = (depth_now > 0) ? entries[depth_now - 1] : 32'd0;
      res.depth  = depth_now[6:0];
      res.single = (depth_now == 1);
      pending.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(logic [47:0] w);
      rpn_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: word %h with no token waiting for it", $time, w);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("status", want.status, w[2:0]);
      compare_field("top_value", want.top, w[34:3]);
      compare_field("depth", want.depth, w[41:35]);
      compare_field("single_result", want.single, w[42]);
      compare_field("padding", 32'd0, w[47:43]);
    endfunction

    function int outstanding();
      return pending.size();
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;  // number[31:0], operator_code[39:32]
  logic [0:0]  s_tuser  = '0;  // cmd[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // status, top_value, depth, single_result, zero

  rpn_checker evaluator = new();
  int         tokens_sent = 0;
  bit         tx_lazy = 1'b1;

  postfix_stack_evaluator_unit #(
    .STACK_DEPTH(STACK_DEPTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_token(input bit is_op, input logic [31:0] num, input logic [7:0] opc);
    int gap;
    gap = tx_lazy ? $urandom_range(0, 6) : 0;
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {opc, num};
    s_tuser  <= is_op;
    do @(posedge clk); while (!s_tready);
    evaluator.note_token(is_op, num, opc);
    tokens_sent++;
  endtask

  task automatic push_num(input logic [31:0] v);
    send_token(1'b0, v, 8'($urandom_range(0, 255)));
  endtask

  task automatic apply_op(input logic [7:0] c);
    send_token(1'b1, $urandom, c);
  endtask

  function automatic logic [31:0] rand_q();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 32'h0014_0000) - 32'h000A_0000;  // about +-10.0
      4, 5: v = $urandom;
      6: begin
        v = $urandom_range(32'h0100_0000, 32'h7FFF_FFFF);
        if ($urandom_range(0, 1)) v = -v;
      end
      7: begin
        case ($urandom_range(0, 5))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          3: v = 32'h0000_0001;
          4: v = 32'hFFFF_FFFF;
          default: v = 32'h0001_0000;
        endcase
      end
      default: begin
        v = $urandom_range(0, 16);
        v = (v - 32'd8) << FRAC_BITS;  // small whole numbers, zero among them
      end
    endcase
    return v;
  endfunction

  function automatic logic [7:0] pick_valid_op();
    case ($urandom_range(0, 3))
      0: return pse_pkg::CHAR_ADD;
      1: return pse_pkg::CHAR_SUB;
      2: return pse_pkg::CHAR_MUL;
      default: return pse_pkg::CHAR_DIV;
    endcase
  endfunction

  function automatic logic [7:0] pick_op();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return pick_valid_op();
  endfunction

  // run the stack up to its limit, push past it, then fold it back to one entry
  task automatic fill_and_drain();
    while (evaluator.depth_now < STACK_DEPTH) push_num(rand_q());
    repeat ($urandom_range(1, 3)) push_num(rand_q());
    while (evaluator.depth_now > 1) apply_op(pick_valid_op());
  endtask

  initial begin : stimulus
    bit want_op;
    int first_random;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty and short stacks, saturation both ways, rounding, bad input
    apply_op(pse_pkg::CHAR_ADD);
    push_num(32'h7FFF_FFFF);
    apply_op(8'h25);
    push_num(32'h0000_0001);
    apply_op(pse_pkg::CHAR_ADD);
    push_num(32'h8000_0000);
    apply_op(pse_pkg::CHAR_SUB);
    push_num(32'h0000_0000);
    apply_op(pse_pkg::CHAR_DIV);
    apply_op(8'h00);
    apply_op(8'hFF);
    apply_op(pse_pkg::CHAR_MUL);
    push_num(32'hFFFF_FFFF);
    push_num(32'h0000_8000);
    apply_op(pse_pkg::CHAR_MUL);
    push_num(32'h0000_0001);
    apply_op(pse_pkg::CHAR_DIV);
    push_num(32'h8000_0000);
    push_num(32'h8000_0000);
    apply_op(pse_pkg::CHAR_MUL);
    push_num(32'h8000_0000);
    push_num(32'h0000_0001);
    apply_op(pse_pkg::CHAR_SUB);
    push_num(32'hFFFF_0000);
    apply_op(pse_pkg::CHAR_DIV);

    first_random = tokens_sent;
    fill_and_drain();
    while (tokens_sent < first_random + RANDOM_TOKENS) begin
      if (tokens_sent % 100 == 0) tx_lazy = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 299) == 0) begin
        fill_and_drain();
      end else begin
        if (evaluator.depth_now < 2) want_op = ($urandom_range(0, 99) < 12);
        else if (evaluator.depth_now > 10) want_op = ($urandom_range(0, 99) < 70);
        else want_op = ($urandom_range(0, 99) < 48);
        if (want_op) apply_op(pick_op());
        else push_num(rand_q());
      end
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    while (evaluator.outstanding() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (evaluator.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : result_sink
    int  wait_n;
    int  words;
    bit  rx_lazy;
    words   = 0;
    rx_lazy = 1'b1;
    while (rst) @(posedge clk);
    forever begin
      if (words % 100 == 0) rx_lazy = ($urandom_range(0, 2) != 0);
      wait_n = rx_lazy ? $urandom_range(0, 6) : 0;
      // long back-pressure so the unit fills and stalls its input
      if (words == 200 || words == 800) wait_n = LONG_HOLD;
      repeat (wait_n) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      evaluator.check_word(m_tdata);
      words++;
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
